@@ sv/imu_fp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fp_pkg
// Shared types and constants for the 11-byte sum-checked IMU frame parser.
// ----------------------------------------------------------------------------
package imu_fp_pkg;

  localparam int FrameLen         = 11;
  localparam int SumBytes         = 10;
  localparam int SampleIndexLimit = 255;
  // the count is 8 bits wide, so a larger limit acts as 255
  localparam int CountCapInt      = (SampleIndexLimit > 255) ? 255 : SampleIndexLimit;
  localparam logic [7:0] CountCap = CountCapInt[7:0];

  localparam logic [7:0] HeaderByte = 8'h55;
  localparam logic [7:0] TypeAccel  = 8'h51;
  localparam logic [7:0] TypeRate   = 8'h52;
  localparam logic [7:0] TypeAngle  = 8'h53;

  localparam logic [3:0] FillFull = 4'(FrameLen);

  typedef logic [7:0]                  rx_byte_t;
  typedef rx_byte_t [FrameLen-1:0]     window_t;
  typedef logic [3:0]                  fill_t;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_RATE  = 2'd1,
    KIND_ANGLE = 2'd2
  } frame_kind_e;

  typedef struct packed {
    logic               hit;
    frame_kind_e        kind;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } check_t;

endpackage

@@ sv/imu_fp_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fp_window
// Sliding window of the last eleven bytes of the current burst and its fill
// count; presents the window as it stands after the incoming byte.
// ----------------------------------------------------------------------------
module imu_fp_window (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  logic                clear_i,
  input  imu_fp_pkg::rx_byte_t byte_i,
  output imu_fp_pkg::window_t win_o,
  output imu_fp_pkg::fill_t   fill_o
);
  import imu_fp_pkg::*;

  window_t win_q, win_d;
  fill_t   fill_q, fill_d;
  window_t win_base;
  fill_t   fill_base;

  always_comb begin
    // a new burst starts from an empty window
    win_base  = clear_i ? '0 : win_q;
    fill_base = clear_i ? '0 : fill_q;
    for (int i = 0; i < FrameLen - 1; i++) begin
      win_d[i] = win_base[i+1];
    end
    win_d[FrameLen-1] = byte_i;
    fill_d = (fill_base < FillFull) ? fill_base + 4'd1 : fill_base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= '0;
    end else if (shift_i) begin
      win_q  <= win_d;
      fill_q <= fill_d;
    end
  end

  assign win_o  = win_d;
  assign fill_o = fill_d;

endmodule

@@ sv/imu_fp_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fp_check
// Frame test on one window: header, 8-bit sum, type decode and the three
// little-endian axis values.
// ----------------------------------------------------------------------------
module imu_fp_check (
  input  imu_fp_pkg::window_t win_i,
  input  imu_fp_pkg::fill_t   fill_i,
  output imu_fp_pkg::check_t  chk_o
);
  import imu_fp_pkg::*;

  logic [7:0] sum_lo, sum_hi, sum;
  logic       type_ok;
  frame_kind_e kind;

  always_comb begin
    // two five-byte halves keep the adder chain short
    sum_lo = '0;
    sum_hi = '0;
    for (int i = 0; i < SumBytes / 2; i++) begin
      sum_lo = sum_lo + win_i[i];
      sum_hi = sum_hi + win_i[i + SumBytes / 2];
    end
    sum = sum_lo + sum_hi;
  end

  always_comb begin
    type_ok = 1'b1;
    kind    = KIND_ACCEL;
    unique case (win_i[1])
      TypeAccel: kind = KIND_ACCEL;
      TypeRate:  kind = KIND_RATE;
      TypeAngle: kind = KIND_ANGLE;
      default:   type_ok = 1'b0;
    endcase
  end

  always_comb begin
    chk_o.hit    = (fill_i == FillFull) && (win_i[0] == HeaderByte) &&
                   (sum == win_i[SumBytes]) && type_ok;
    chk_o.kind   = kind;
    chk_o.axis_x = signed'({win_i[3], win_i[2]});
    chk_o.axis_y = signed'({win_i[5], win_i[4]});
    chk_o.axis_z = signed'({win_i[7], win_i[6]});
  end

endmodule

@@ sv/imu_frame_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_parser_core
// Byte-stream parser for 11-byte sum-checked IMU frames with per-kind indices.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while in_stall_o is low. If a byte completes a
// valid frame, its result is registered: the byte waits in the input register,
// then makes a single pass through the window shift, the ten-byte sum and
// compare and the type decode into the result register. Every
// byte offset is tested, so overlapping frames are all found. burst_start_i
// clears the window and the per-kind sample counts before its byte is taken; a
// frame needs eleven bytes of the same burst. Each frame's sample_index_o counts
// earlier frames of its kind in the burst and holds at 255. in_stall_o rises
// only while a result waits on out_stall_i and a byte already sits in the input
// register.
module imu_frame_parser_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               burst_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         frame_kind_o,
  output logic signed [15:0] axis_x_o,
  output logic signed [15:0] axis_y_o,
  output logic signed [15:0] axis_z_o,
  output logic [7:0]         sample_index_o
);
  import imu_fp_pkg::*;

  // input register
  logic     s1_valid_q, s1_valid_d;
  rx_byte_t s1_byte_q;
  logic     s1_start_q;

  logic     in_accept;
  logic     advance;

  window_t  win;
  fill_t    fill;
  check_t   chk;

  logic [7:0] cnt_q [3];
  logic [7:0] cnt_sel;

  logic               out_valid_q, out_valid_d;
  frame_kind_e        kind_q;
  logic signed [15:0] axis_x_q, axis_y_q, axis_z_q;
  logic [7:0]         index_q;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q  <= rx_byte_i;
      s1_start_q <= burst_start_i;
    end
  end

  imu_fp_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (advance),
    .clear_i (s1_start_q),
    .byte_i  (s1_byte_q),
    .win_o   (win),
    .fill_o  (fill)
  );

  imu_fp_check u_check (
    .win_i  (win),
    .fill_i (fill),
    .chk_o  (chk)
  );

  always_comb begin
    case (chk.kind)
      KIND_RATE:  cnt_sel = cnt_q[1];
      KIND_ANGLE: cnt_sel = cnt_q[2];
      default:    cnt_sel = cnt_q[0];
    endcase
  end

  // per-kind sample counts, cleared at a new burst
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        cnt_q[k] <= '0;
      end
    end else if (advance) begin
      if (s1_start_q) begin
        for (int k = 0; k < 3; k++) begin
          cnt_q[k] <= '0;
        end
      end else if (chk.hit && (cnt_sel < CountCap)) begin
        case (chk.kind)
          KIND_RATE:  cnt_q[1] <= cnt_sel + 8'd1;
          KIND_ANGLE: cnt_q[2] <= cnt_sel + 8'd1;
          default:    cnt_q[0] <= cnt_sel + 8'd1;
        endcase
      end
    end
  end

  always_comb begin
    if (advance) begin
      out_valid_d = chk.hit;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && chk.hit) begin
      kind_q   <= chk.kind;
      axis_x_q <= chk.axis_x;
      axis_y_q <= chk.axis_y;
      axis_z_q <= chk.axis_z;
      index_q  <= cnt_sel;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_kind_o   = kind_q;
  assign axis_x_o       = axis_x_q;
  assign axis_y_o       = axis_y_q;
  assign axis_z_o       = axis_z_q;
  assign sample_index_o = index_q;

`ifndef SYNTHESIS
  // a frame is only reported from a full window
  a_hit_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && chk.hit) |-> (fill == FillFull))
    else $error("frame reported from a partial window");

  // a burst start never completes a frame on its own byte
  a_start_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_start_q) |=> !out_valid_o)
    else $error("result on the first byte of a burst");

  // a taken result with nothing behind it leaves the output empty
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !advance) |=> !out_valid_o)
    else $error("result repeated after it was taken");

  // the input side stalls only when it holds a byte it cannot pass on
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");
`endif

endmodule

@@ tb/sv/imu_frame_parser_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_parser_core_tb
// Self-checking bench for the IMU frame parser. Byte requests are driven with
// random gaps and output stalls. A frame tracker mirrors the window, checksum
// and per-kind counts and checks every frame the block reports, field by field.
// ----------------------------------------------------------------------------
module imu_frame_parser_core_tb;
  import imu_fp_pkg::*;

  localparam int ItemsTarget = 1300;
  localparam int DenseBytes  = 810;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 16;

  typedef logic [7:0] frame_bytes_t [FrameLen];

  typedef struct {
    frame_kind_e        kind;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic [7:0]         sample_index;
  } imu_frame_t;

  // mirrors the sliding window and the per-kind counts of one burst
  class frame_tracker;
    logic [7:0] window [FrameLen];
    logic [3:0] fill;
    logic [7:0] kind_count [3];
    imu_frame_t frames_due [$];
    int         errors;

    function new();
      clear_burst();
      errors = 0;
    endfunction

    function void clear_burst();
      foreach (window[i]) window[i] = 8'h00;
      foreach (kind_count[i]) kind_count[i] = 8'h00;
      fill = 4'd0;
    endfunction

    function void take_byte(logic [7:0] b, logic first);
      logic [7:0] sum;
      frame_kind_e kind;
      imu_frame_t fr;
      if (first) clear_burst();
      for (int i = 0; i < FrameLen - 1; i++) window[i] = window[i + 1];
      window[FrameLen - 1] = b;
      if (fill < FillFull) fill++;
      if (fill < FillFull || window[0] != HeaderByte) return;
      sum = 8'h00;
      for (int i = 0; i < SumBytes; i++) sum += window[i];
      if (sum != window[SumBytes]) return;
      case (window[1])
        TypeAccel: kind = KIND_ACCEL;
        TypeRate:  kind = KIND_RATE;
        TypeAngle: kind = KIND_ANGLE;
        default:   return;
      endcase
      fr.kind         = kind;
      fr.axis_x       = {window[3], window[2]};
      fr.axis_y       = {window[5], window[4]};
      fr.axis_z       = {window[7], window[6]};
      fr.sample_index = kind_count[kind];
      if (kind_count[kind] < CountCap) kind_count[kind]++;
      frames_due.push_back(fr);
    endfunction

    function void check_frame(logic [1:0] kind, logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z, logic [7:0] idx);
      imu_frame_t fr;
      if (frames_due.size() == 0) begin
        $error("frame reported with none due: kind %0d x %0d y %0d z %0d index %0d",
               kind, x, y, z, idx);
        errors++;
        return;
      end
      fr = frames_due.pop_front();
      if (kind !== fr.kind) begin
        $error("frame_kind: expected %0d, got %0d", fr.kind, kind);
        errors++;
      end
      if (x !== fr.axis_x) begin
        $error("axis_x: expected %0d, got %0d", fr.axis_x, x);
        errors++;
      end
      if (y !== fr.axis_y) begin
        $error("axis_y: expected %0d, got %0d", fr.axis_y, y);
        errors++;
      end
      if (z !== fr.axis_z) begin
        $error("axis_z: expected %0d, got %0d", fr.axis_z, z);
        errors++;
      end
      if (idx !== fr.sample_index) begin
        $error("sample_index: expected %0d, got %0d", fr.sample_index, idx);
        errors++;
      end
    endfunction

    function int frames_waiting();
      return frames_due.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic [7:0]         rx_byte = 8'h00;
  logic               burst_start = 1'b0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [1:0]         frame_kind;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;
  logic [7:0]         sample_index;

  frame_tracker tracker = new();
  bit           no_idle = 1'b0;
  bit           hold_req = 1'b0;
  int           bytes_sent = 0;

  imu_frame_parser_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .burst_start_i  (burst_start),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .frame_kind_o   (frame_kind),
    .axis_x_o       (axis_x),
    .axis_y_o       (axis_y),
    .axis_z_o       (axis_z),
    .sample_index_o (sample_index)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // one byte request, after a random gap
  task automatic send_byte(input logic [7:0] b, input logic first);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    rx_byte     <= b;
    burst_start <= first;
    do @(posedge clk); while (in_stall);
    tracker.take_byte(b, first);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_bytes_t f, input int cnt, input logic first);
    for (int i = 0; i < cnt; i++) send_byte(f[i], first && (i == 0));
  endtask

  function automatic frame_bytes_t build_frame(logic [7:0] typ, logic [15:0] x,
                                               logic [15:0] y, logic [15:0] z,
                                               logic [7:0] pad0, logic [7:0] pad1,
                                               logic corrupt);
    frame_bytes_t f;
    logic [7:0] sum;
    f = '{HeaderByte, typ, x[7:0], x[15:8], y[7:0], y[15:8], z[7:0], z[15:8],
          pad0, pad1, 8'h00};
    sum = 8'h00;
    for (int i = 0; i < SumBytes; i++) sum += f[i];
    f[SumBytes] = corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum;
    return f;
  endfunction

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 2))
      0:       return TypeAccel;
      1:       return TypeRate;
      default: return TypeAngle;
    endcase
  endfunction

  function automatic frame_bytes_t random_frame(logic [7:0] typ, logic corrupt);
    return build_frame(typ, pick_axis(), pick_axis(), pick_axis(),
                       8'($urandom), 8'($urandom), corrupt);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int w;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        w = no_idle ? 0 : $urandom_range(0, 15);
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      tracker.check_frame(frame_kind, axis_x, axis_y, axis_z, sample_index);
    end
  end

  initial begin
    frame_bytes_t f;
    logic [7:0]   typ;
    logic [7:0]   filler;
    logic         first;
    logic         force_first;
    int           sel;
    int           pkt;
    int           v;
    int           guard;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // short burst: a header and type that must not join the next burst
    send_byte(HeaderByte, 1'b1);
    send_byte(TypeAccel, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    // new burst, extreme axes
    f = build_frame(TypeAccel, 16'h8000, 16'h7fff, 16'hffff, 8'hff, 8'h00, 1'b0);
    send_frame(f, FrameLen, 1'b1);
    // good header and checksum, unknown type
    f = build_frame(8'hff, 16'h0000, 16'h0001, 16'h8001, 8'h00, 8'hff, 1'b0);
    send_frame(f, FrameLen, 1'b0);

    // dense burst: 55 type filler repeats so every third offset is a frame,
    // enough frames to drive one kind count into its hold
    typ = pick_type();
    v = -(4 * HeaderByte) - 2 * typ;
    v = ((v % 256) + 256) % 256;
    filler = 8'((v * 171) % 256);
    no_idle = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < DenseBytes; i++) begin
      if (i == 60) no_idle = 1'b0;
      case (i % 3)
        0:       send_byte(HeaderByte, i == 0);
        1:       send_byte(typ, 1'b0);
        default: send_byte(filler, 1'b0);
      endcase
    end

    pkt = 0;
    force_first = 1'b1;
    while (bytes_sent < ItemsTarget) begin
      pkt++;
      if (pkt % 30 == 0) no_idle = ($urandom_range(0, 3) == 0);
      first = force_first || ($urandom_range(0, 4) == 0);
      force_first = 1'b0;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        send_frame(random_frame(pick_type(), 1'b0), FrameLen, first);
      end else if (sel < 70) begin
        do typ = 8'($urandom); while (typ >= TypeAccel && typ <= TypeAngle);
        send_frame(random_frame(typ, 1'b0), FrameLen, first);
      end else if (sel < 80) begin
        send_frame(random_frame(pick_type(), 1'b1), FrameLen, first);
      end else if (sel < 90) begin
        // cut short, the next burst starts mid-frame
        send_frame(random_frame(pick_type(), 1'b0), $urandom_range(1, FrameLen - 1), first);
        force_first = 1'b1;
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_byte(($urandom_range(0, 2) == 0) ? HeaderByte : 8'($urandom),
                    $urandom_range(0, 15) == 0);
        end
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    no_idle = 1'b0;
    guard = 0;
    while (tracker.frames_waiting() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DrainCycles) @(posedge clk);

    if (tracker.errors == 0 && tracker.frames_waiting() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (tracker.frames_waiting() != 0) begin
        $error("%0d frames expected but never reported", tracker.frames_waiting());
      end
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
